FILE: rtl/core/audio_period_ring_buffer_core_assert.svh
// ----------------------------------------------------------------------------
// audio period ring buffer assertion macros
// clocked assertion helpers used by the port checker
// ----------------------------------------------------------------------------
`ifndef AUDIO_PERIOD_RING_BUFFER_CORE_ASSERT_SVH
`define AUDIO_PERIOD_RING_BUFFER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define APR_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication with the consequent checked after a delay
`define APR_ASSERT_DELAY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/apr_pkg.sv
// ----------------------------------------------------------------------------
// audio period ring buffer package
// payload types, codes, sizing constants and ring length helpers
// ----------------------------------------------------------------------------
package apr_pkg;

   localparam int unsigned PERIOD_FRAMES   = 512;
   localparam int unsigned MAX_RING_FRAMES = 32768;
   localparam int unsigned SAMPLE_RATE     = 48000;
   localparam int unsigned MS_PER_S        = 1000;
   localparam int unsigned FRAMES_PER_MS   = SAMPLE_RATE / MS_PER_S;
   localparam int unsigned MIN_PERIODS     = 5;
   localparam int unsigned MAX_PERIODS     = 64;
   localparam int unsigned LAT_RESET       = 64;

   localparam int unsigned PERIOD_SHIFT = $clog2(PERIOD_FRAMES);
   localparam int unsigned PTR_W        = $clog2(MAX_RING_FRAMES);
   localparam int unsigned LEN_W        = PTR_W + 1;
   localparam int unsigned OFS_W        = PERIOD_SHIFT;
   localparam int unsigned LAT_W        = 10;

   localparam int unsigned HI_RAW     = MAX_RING_FRAMES / PERIOD_FRAMES;
   localparam int unsigned HI_CAP     = (HI_RAW < MAX_PERIODS) ? HI_RAW : MAX_PERIODS;
   localparam int unsigned HI_PERIODS = (HI_CAP < 1) ? 1 : HI_CAP;
   localparam int unsigned LO_PERIODS = (MIN_PERIODS > HI_PERIODS) ? HI_PERIODS : MIN_PERIODS;

   localparam logic [1:0] OP_OPEN  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FETCH = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_STRAY   = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] burst_frames;
      logic [31:0] frame_in;
   } apr_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] accepted_frames;
      logic [31:0] frame_out;
      logic        silent;
      logic        period_end;
      logic [14:0] free_frames;
      logic [31:0] underrun_count;
      logic [47:0] consumed_count;
   } apr_rsp_type;

   typedef struct packed {
      apr_rsp_type rsp;
      logic        fetch_read;
   } apr_step_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic [31:0]      wr_data;
      logic [PTR_W-1:0] rd_addr;
   } apr_mem_req_type;

   function automatic logic [LEN_W-1:0] ring_len_for(logic [LAT_W-1:0] lat);
      int unsigned f;
      int unsigned periods;
      f = FRAMES_PER_MS * 32'(lat);
      f = (f > PERIOD_FRAMES) ? f - PERIOD_FRAMES : 0;
      periods = (f + PERIOD_FRAMES - 1) >> PERIOD_SHIFT;
      if (periods < LO_PERIODS) periods = LO_PERIODS;
      if (periods > HI_PERIODS) periods = HI_PERIODS;
      return LEN_W'(periods << PERIOD_SHIFT);
   endfunction

   function automatic logic [LEN_W-1:0] held_of(logic [PTR_W-1:0] wp, logic [PTR_W-1:0] rp,
                                                logic [LEN_W-1:0] len);
      if (wp >= rp) return LEN_W'(wp) - LEN_W'(rp);
      return len - LEN_W'(rp) + LEN_W'(wp);
   endfunction

   function automatic logic [LEN_W-1:0] free_of(logic [PTR_W-1:0] wp, logic [PTR_W-1:0] rp,
                                                logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] h;
      logic [LEN_W-1:0] lm1;
      h   = held_of(wp, rp, len);
      lm1 = len - LEN_W'(1);
      return (lm1 > h) ? lm1 - h : '0;
   endfunction

endpackage

FILE: rtl/core/audio_period_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// audio period ring buffer core
// stereo frame ring between a burst writer and a period-based device reader
// ----------------------------------------------------------------------------
// channels: a command transfer on start while busy is low carries req_data
// (open burst, write frame or device fetch); every command yields exactly one
// result on rsp_data, marked by rsp_strobe for a single cycle.
// csr_we with csr_wdata sets the latency in ms; this resizes and empties the
// ring while the underrun and consumed counters keep counting.
// the command is held in the input register, then the result passes through
// the pointer logic and is registered together with the read of the frame
// store.
// throughput: one command per cycle, busy never rises; the single frame store
// port pair (one write, one read per cycle) sets that figure.
// reset: pointers, open burst, period state and counters clear, latency
// returns to 64 ms; the frame store keeps its contents.
// the receiver cannot stall: each result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module audio_period_ring_buffer_core
   import apr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  apr_req_type      req_data,
   output logic             rsp_strobe,
   output apr_rsp_type      rsp_data,
   input  logic             csr_we,
   input  logic [LAT_W-1:0] csr_wdata
);

   logic            in_valid_ff;
   apr_req_type     in_ff;
   logic            rsp_valid_ff;
   apr_rsp_type     rsp_ff;
   logic            fetch_read_ff;
   apr_step_type    step;
   apr_mem_req_type mem_req;
   logic [31:0]     rd_data;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= start && !busy;
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_ff         <= req_data;
      rsp_ff        <= step.rsp;
      fetch_read_ff <= step.fetch_read;
   end

   apr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (in_valid_ff),
      .item       (in_ff),
      .step       (step),
      .mem_req    (mem_req)
   );

   apr_ring_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.frame_out = fetch_read_ff ? rd_data : '0;
   end

   assign rsp_strobe = rsp_valid_ff;

endmodule

FILE: rtl/core/apr_ring_mem.sv
// ----------------------------------------------------------------------------
// audio period ring buffer frame store
// one write port and one registered read port over the frame ring
// ----------------------------------------------------------------------------
module apr_ring_mem
   import apr_pkg::*;
(
   input  logic            clock,
   input  apr_mem_req_type mem_req,
   output logic [31:0]     rd_data
);

   logic [31:0] ring_ff [MAX_RING_FRAMES];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ring_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= ring_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/apr_ctrl.sv
// ----------------------------------------------------------------------------
// audio period ring buffer pointer control
// burst grants, write publishing, period playback and counters
// ----------------------------------------------------------------------------
module apr_ctrl
   import apr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [LAT_W-1:0] csr_wdata,
   input  logic             item_valid,
   input  apr_req_type      item,
   output apr_step_type     step,
   output apr_mem_req_type  mem_req
);

   logic [PTR_W-1:0] pub_ff, pub_in;
   logic [PTR_W-1:0] pend_ff, pend_in;
   logic [PTR_W-1:0] burst_ff, burst_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic             silent_ff, silent_in;
   logic [31:0]      underruns_ff, underruns_in;
   logic [47:0]      consumed_ff, consumed_in;
   logic [LEN_W-1:0] ring_len_ff, ring_len_in;

   logic [PTR_W-1:0] pub_open;
   logic [LEN_W-1:0] len_m1;
   logic [LEN_W-1:0] req_clamp;
   logic [LEN_W-1:0] free_open;
   logic [LEN_W-1:0] held_now;
   logic [LEN_W-1:0] pend_inc;
   logic [PTR_W-1:0] pend_wrap;
   logic [LEN_W-1:0] rd_step;
   logic [PTR_W-1:0] rd_wrap;
   logic             silent_cur;
   logic             last_frame;
   logic [1:0]       status;
   logic [LEN_W-1:0] accepted;
   logic             sil;
   logic             pend_out;
   logic             fetch_read;

   always_comb begin
      pub_in       = pub_ff;
      pend_in      = pend_ff;
      burst_in     = burst_ff;
      rd_in        = rd_ff;
      offset_in    = offset_ff;
      silent_in    = silent_ff;
      underruns_in = underruns_ff;
      consumed_in  = consumed_ff;
      ring_len_in  = ring_len_ff;
      status       = ST_OK;
      accepted     = '0;
      sil          = 1'b0;
      pend_out     = 1'b0;
      fetch_read   = 1'b0;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = pend_ff;
      mem_req.wr_data = item.frame_in;
      mem_req.rd_addr = rd_ff + PTR_W'(offset_ff);

      pub_open   = (burst_ff != '0) ? pend_ff : pub_ff;
      len_m1     = ring_len_ff - LEN_W'(1);
      req_clamp  = (32'(item.burst_frames) > 32'(len_m1)) ? len_m1
                                                          : LEN_W'(item.burst_frames);
      free_open  = free_of(pub_open, rd_ff, ring_len_ff);
      held_now   = held_of(pub_ff, rd_ff, ring_len_ff);
      pend_inc   = LEN_W'(pend_ff) + LEN_W'(1);
      pend_wrap  = (pend_inc >= ring_len_ff) ? '0 : PTR_W'(pend_inc);
      rd_step    = LEN_W'(rd_ff) + LEN_W'(PERIOD_FRAMES);
      rd_wrap    = (rd_step >= ring_len_ff) ? '0 : PTR_W'(rd_step);
      silent_cur = (offset_ff == '0) ? (held_now < LEN_W'(PERIOD_FRAMES)) : silent_ff;
      last_frame = (offset_ff == OFS_W'(PERIOD_FRAMES - 1));

      if (item_valid) begin
         case (item.opcode)
            OP_OPEN: begin
               pub_in   = pub_open;
               burst_in = '0;
               if (req_clamp != '0) begin
                  if (free_open < req_clamp) begin
                     status = ST_REFUSED;
                  end else begin
                     accepted = req_clamp;
                     burst_in = PTR_W'(req_clamp);
                     pend_in  = pub_open;
                  end
               end
            end
            OP_WRITE: begin
               if (burst_ff == '0) begin
                  status = ST_STRAY;
               end else begin
                  mem_req.wr_en = 1'b1;
                  pend_in       = pend_wrap;
                  burst_in      = burst_ff - PTR_W'(1);
                  if (burst_ff == PTR_W'(1)) begin
                     pub_in = pend_wrap;
                  end
               end
            end
            OP_FETCH: begin
               silent_in  = silent_cur;
               sil        = silent_cur;
               fetch_read = !silent_cur;
               if ((offset_ff == '0) && silent_cur) begin
                  underruns_in = underruns_ff + 32'd1;
               end
               if (last_frame) begin
                  pend_out    = 1'b1;
                  offset_in   = '0;
                  consumed_in = consumed_ff + 48'(PERIOD_FRAMES);
                  if (!silent_cur) begin
                     rd_in = rd_wrap;
                  end
               end else begin
                  offset_in = offset_ff + OFS_W'(1);
               end
            end
            default: begin
            end
         endcase
      end

      step.rsp.status          = status;
      step.rsp.accepted_frames = 15'(accepted);
      step.rsp.frame_out       = '0;
      step.rsp.silent          = sil;
      step.rsp.period_end      = pend_out;
      step.rsp.free_frames     = 15'(free_of(pub_in, rd_in, ring_len_in));
      step.rsp.underrun_count  = underruns_in;
      step.rsp.consumed_count  = consumed_in;
      step.fetch_read          = fetch_read;

      // latency change empties the ring, counters survive
      if (csr_we) begin
         ring_len_in = ring_len_for(csr_wdata);
         pub_in      = '0;
         pend_in     = '0;
         burst_in    = '0;
         rd_in       = '0;
         offset_in   = '0;
         silent_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pub_ff       <= '0;
         pend_ff      <= '0;
         burst_ff     <= '0;
         rd_ff        <= '0;
         offset_ff    <= '0;
         silent_ff    <= 1'b0;
         underruns_ff <= '0;
         consumed_ff  <= '0;
         ring_len_ff  <= ring_len_for(LAT_W'(LAT_RESET));
      end else begin
         pub_ff       <= pub_in;
         pend_ff      <= pend_in;
         burst_ff     <= burst_in;
         rd_ff        <= rd_in;
         offset_ff    <= offset_in;
         silent_ff    <= silent_in;
         underruns_ff <= underruns_in;
         consumed_ff  <= consumed_in;
         ring_len_ff  <= ring_len_in;
      end
   end

endmodule

FILE: rtl/core/apr_checker.sv
// ----------------------------------------------------------------------------
// audio period ring buffer port checker
// timing and result consistency checks seen from the top level ports
// ----------------------------------------------------------------------------
`include "audio_period_ring_buffer_core_assert.svh"

module apr_checker
   import apr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input apr_rsp_type rsp_data
);

   logic [47:0] period_mask;
   logic        cmd_xfer;
   logic        rsp_err;
   logic        rsp_quiet;
   logic        end_whole;

   assign period_mask = 48'(PERIOD_FRAMES - 1);
   assign cmd_xfer    = start && !busy;
   assign rsp_err     = rsp_strobe && (rsp_data.status != ST_OK);
   assign rsp_quiet   = (rsp_data.frame_out == '0) && !rsp_data.silent &&
                        !rsp_data.period_end && (rsp_data.accepted_frames == '0);
   assign end_whole   = (rsp_data.consumed_count & period_mask) == '0;

   `APR_ASSERT_DELAY(a_cmd_gives_rsp, clock, reset, cmd_xfer, rsp_strobe, "command without result")

   `APR_ASSERT_IMPLY(a_rsp_has_cmd, clock, reset, rsp_strobe, $past(cmd_xfer, 2), "stray result")

   `APR_ASSERT_IMPLY(a_err_is_quiet, clock, reset, rsp_err, rsp_quiet, "error result not quiet")

   `APR_ASSERT_IMPLY(a_consumed_whole, clock, reset, rsp_strobe && rsp_data.period_end, end_whole, "consumed off period")

endmodule

bind audio_period_ring_buffer_core apr_checker u_apr_checker (.*);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// audio period ring buffer testbench
// drives open, write and fetch commands through the command port, with a
// short table of hand-checked cases followed by random traffic over several
// latency settings; results are checked against fixed values or a ring model
// ----------------------------------------------------------------------------
module tb_top;
   import apr_pkg::*;

   localparam logic [1:0] OP_SPARE       = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT = 500;
   localparam int unsigned PRINT_LIMIT    = 200;

   typedef struct {
      apr_req_type cmd;
      bit          fixed;
      apr_rsp_type golden;
   } directed_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   apr_req_type      req_data  = '0;
   logic             rsp_strobe;
   apr_rsp_type      rsp_data;
   logic             csr_we    = 1'b0;
   logic [LAT_W-1:0] csr_wdata = '0;

   // ring model state
   logic [31:0] frame_store [MAX_RING_FRAMES];
   int unsigned ring_len;
   int unsigned wr_pub;
   int unsigned wr_pend;
   int unsigned burst_left;
   int unsigned rd_pos;
   int unsigned ofs;
   bit          in_silence;
   logic [31:0] underruns;
   logic [47:0] consumed;

   apr_rsp_type      due_rsp [$];
   directed_row_type plan [$];
   int unsigned   mismatches     = 0;
   int unsigned   items_sent     = 0;
   int unsigned   period_ends    = 0;
   int unsigned   refused_bursts = 0;
   int unsigned   run_left       = 0;
   int unsigned   quiet_cycles   = 0;

   audio_period_ring_buffer_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned ring_frames_for(logic [LAT_W-1:0] lat);
      int unsigned f;
      int unsigned lo;
      int unsigned hi;
      lo = MIN_PERIODS * PERIOD_FRAMES;
      hi = MAX_PERIODS * PERIOD_FRAMES;
      if (hi > MAX_RING_FRAMES) hi = (MAX_RING_FRAMES / PERIOD_FRAMES) * PERIOD_FRAMES;
      if (hi < PERIOD_FRAMES) hi = PERIOD_FRAMES;
      if (lo > hi) lo = hi;
      f = SAMPLE_RATE * int'(lat) / MS_PER_S;
      f = (f > PERIOD_FRAMES) ? f - PERIOD_FRAMES : 0;
      f = ((f + PERIOD_FRAMES - 1) / PERIOD_FRAMES) * PERIOD_FRAMES;
      if (f < lo) f = lo;
      if (f > hi) f = hi;
      return f;
   endfunction

   function automatic int unsigned held_now();
      if (wr_pub >= rd_pos) return wr_pub - rd_pos;
      return ring_len - rd_pos + wr_pub;
   endfunction

   function automatic int unsigned free_now();
      int unsigned h;
      h = held_now();
      return (ring_len - 1 > h) ? ring_len - 1 - h : 0;
   endfunction

   // latency change empties the ring but keeps both counters
   function automatic void set_ring_latency(logic [LAT_W-1:0] lat);
      ring_len   = ring_frames_for(lat);
      wr_pub     = 0;
      wr_pend    = 0;
      burst_left = 0;
      rd_pos     = 0;
      ofs        = 0;
      in_silence = 1'b0;
   endfunction

   function automatic apr_rsp_type ring_step(apr_req_type c);
      apr_rsp_type r;
      int unsigned n;
      r = '0;
      r.status = ST_OK;
      case (c.opcode)
         OP_OPEN: begin
            if (burst_left != 0) begin
               wr_pub     = wr_pend;
               burst_left = 0;
            end
            n = c.burst_frames;
            if (n > ring_len - 1) n = ring_len - 1;
            if (n != 0) begin
               if (free_now() < n) begin
                  r.status = ST_REFUSED;
                  refused_bursts++;
               end else begin
                  r.accepted_frames = 15'(n);
                  burst_left = n;
                  wr_pend    = wr_pub;
               end
            end
         end
         OP_WRITE: begin
            if (burst_left == 0) begin
               r.status = ST_STRAY;
            end else begin
               frame_store[wr_pend] = c.frame_in;
               wr_pend++;
               if (wr_pend >= ring_len) wr_pend = 0;
               burst_left--;
               if (burst_left == 0) wr_pub = wr_pend;
            end
         end
         OP_FETCH: begin
            if (ofs == 0) begin
               if (held_now() < PERIOD_FRAMES) begin
                  in_silence = 1'b1;
                  underruns++;
               end else begin
                  in_silence = 1'b0;
               end
            end
            r.silent = in_silence;
            if (!in_silence) r.frame_out = frame_store[rd_pos + ofs];
            ofs++;
            if (ofs >= PERIOD_FRAMES) begin
               r.period_end = 1'b1;
               ofs          = 0;
               consumed     = consumed + 48'(PERIOD_FRAMES);
               period_ends++;
               if (!in_silence) begin
                  rd_pos += PERIOD_FRAMES;
                  if (rd_pos >= ring_len) rd_pos = 0;
               end
            end
         end
         default: ;
      endcase
      r.free_frames    = 15'(free_now());
      r.underrun_count = underruns;
      r.consumed_count = consumed;
      return r;
   endfunction

   function automatic apr_req_type cmd_of(logic [1:0] op, logic [15:0] n, logic [31:0] f);
      apr_req_type c;
      c.opcode       = op;
      c.burst_frames = n;
      c.frame_in     = f;
      return c;
   endfunction

   function automatic apr_rsp_type rsp_of(logic [1:0] st, logic [14:0] acc, logic [31:0] fo,
                                          logic sil, logic pend, logic [14:0] room,
                                          logic [31:0] und, logic [47:0] cons);
      apr_rsp_type r;
      r.status          = st;
      r.accepted_frames = acc;
      r.frame_out       = fo;
      r.silent          = sil;
      r.period_end      = pend;
      r.free_frames     = room;
      r.underrun_count  = und;
      r.consumed_count  = cons;
      return r;
   endfunction

   function automatic void add_row(apr_req_type c, bit fixed, apr_rsp_type g);
      directed_row_type row;
      row.cmd    = c;
      row.fixed  = fixed;
      row.golden = g;
      plan.push_back(row);
   endfunction

   // mostly well-formed traffic: fill while the device is starved, then play
   function automatic apr_req_type pick_cmd(int unsigned pct_hungry, int unsigned pct_live);
      apr_req_type c;
      bit          hungry;
      c.opcode       = OP_FETCH;
      c.burst_frames = 16'($urandom);
      c.frame_in     = $urandom;
      hungry = (ofs == 0) && (held_now() < PERIOD_FRAMES);
      if ($urandom_range(0, 99) < 6) begin
         c.opcode = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 1) c.burst_frames = 16'($urandom_range(0, 8));
      end else if ($urandom_range(0, 99) < (hungry ? pct_hungry : pct_live)) begin
         c.opcode = OP_FETCH;
      end else if (burst_left != 0) begin
         c.opcode = OP_WRITE;
      end else begin
         c.opcode       = OP_OPEN;
         c.burst_frames = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(49, 700))
                                                      : 16'($urandom_range(1, 48));
      end
      return c;
   endfunction

   task automatic issue(input apr_req_type c, input bit fixed, input apr_rsp_type g);
      int unsigned gap;
      apr_rsp_type want;
      if (run_left == 0) begin
         run_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 30);
         gap      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      run_left--;
      start    <= 1'b1;
      req_data <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = ring_step(c);
      due_rsp.push_back(fixed ? g : want);
      items_sent++;
   endtask

   task automatic run_random(input int unsigned count, input int unsigned pct_hungry,
                             input int unsigned pct_live);
      repeat (count) issue(pick_cmd(pct_hungry, pct_live), 1'b0, '0);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_latency(input logic [LAT_W-1:0] lat);
      csr_wdata <= lat;
      csr_we    <= 1'b1;
      @(posedge clock);
      set_ring_latency(lat);
      csr_we    <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      apr_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
         end else begin
            want = due_rsp.pop_front();
            check_field("status", 48'(want.status), 48'(rsp_data.status));
            check_field("accepted_frames", 48'(want.accepted_frames),
                        48'(rsp_data.accepted_frames));
            check_field("frame_out", 48'(want.frame_out), 48'(rsp_data.frame_out));
            check_field("silent", 48'(want.silent), 48'(rsp_data.silent));
            check_field("period_end", 48'(want.period_end), 48'(rsp_data.period_end));
            check_field("free_frames", 48'(want.free_frames), 48'(rsp_data.free_frames));
            check_field("underrun_count", 48'(want.underrun_count),
                        48'(rsp_data.underrun_count));
            check_field("consumed_count", want.consumed_count, rsp_data.consumed_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, due_rsp.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      underruns = '0;
      consumed  = '0;
      set_ring_latency(LAT_W'(LAT_RESET));

      // reset ring is five periods, so room is 2559
      add_row(cmd_of(OP_FETCH, 16'd0, 32'd0), 1'b1,
              rsp_of(ST_OK, 15'd0, 32'd0, 1'b1, 1'b0, 15'd2559, 32'd1, 48'd0));
      add_row(cmd_of(OP_WRITE, 16'd0, 32'hFFFF_FFFF), 1'b1,
              rsp_of(ST_STRAY, 15'd0, 32'd0, 1'b0, 1'b0, 15'd2559, 32'd1, 48'd0));
      add_row(cmd_of(OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
              rsp_of(ST_OK, 15'd0, 32'd0, 1'b0, 1'b0, 15'd2559, 32'd1, 48'd0));
      add_row(cmd_of(OP_OPEN, 16'd0, 32'd0), 1'b1,
              rsp_of(ST_OK, 15'd0, 32'd0, 1'b0, 1'b0, 15'd2559, 32'd1, 48'd0));
      add_row(cmd_of(OP_OPEN, 16'hFFFF, 32'd0), 1'b1,
              rsp_of(ST_OK, 15'd2559, 32'd0, 1'b0, 1'b0, 15'd2559, 32'd1, 48'd0));
      add_row(cmd_of(OP_OPEN, 16'd3, 32'd0), 1'b1,
              rsp_of(ST_OK, 15'd3, 32'd0, 1'b0, 1'b0, 15'd2559, 32'd1, 48'd0));
      add_row(cmd_of(OP_WRITE, 16'd0, 32'hFFFF_FFFF), 1'b0, '0);
      add_row(cmd_of(OP_WRITE, 16'hFFFF, 32'h0000_0000), 1'b0, '0);
      add_row(cmd_of(OP_WRITE, 16'd0, 32'h5A5A_A5A5), 1'b0, '0);
      add_row(cmd_of(OP_OPEN, 16'd2557, 32'd0), 1'b1,
              rsp_of(ST_REFUSED, 15'd0, 32'd0, 1'b0, 1'b0, 15'd2556, 32'd1, 48'd0));
      add_row(cmd_of(OP_OPEN, 16'd2556, 32'd0), 1'b1,
              rsp_of(ST_OK, 15'd2556, 32'd0, 1'b0, 1'b0, 15'd2556, 32'd1, 48'd0));
      add_row(cmd_of(OP_WRITE, 16'd0, 32'h1234_5678), 1'b0, '0);
      // reopen publishes the one frame written so far
      add_row(cmd_of(OP_OPEN, 16'd2, 32'd0), 1'b0, '0);
      add_row(cmd_of(OP_WRITE, 16'd0, 32'h8000_0001), 1'b0, '0);
      add_row(cmd_of(OP_FETCH, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, '0);
      add_row(cmd_of(OP_SPARE, 16'h5555, 32'hAAAA_AAAA), 1'b0, '0);
      add_row(cmd_of(OP_WRITE, 16'hAAAA, 32'h7FFF_FFFE), 1'b0, '0);
      add_row(cmd_of(OP_WRITE, 16'd0, 32'h0000_FFFF), 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) issue(plan[i].cmd, plan[i].fixed, plan[i].golden);

      settle();
      write_latency(LAT_W'(1000));
      run_random(80, 20, 60);

      settle();
      write_latency(LAT_W'(0));
      run_random(1220, 1, 85);

      settle();
      write_latency(LAT_W'($urandom_range(1, 999)));
      run_random(100, 20, 60);

      settle();
      $display("ran %0d commands over four latency settings", items_sent);
      $display("saw %0d period ends, %0d silent periods and %0d refused bursts",
               period_ends, underruns, refused_bursts);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: audio_period_ring_buffer_core.f
+incdir+rtl/core
rtl/core/apr_pkg.sv
rtl/core/apr_ring_mem.sv
rtl/core/apr_ctrl.sv
rtl/core/audio_period_ring_buffer_core.sv
rtl/core/apr_checker.sv
dv/tb_top.sv
